FILE: hdl/crc8lfr_pkg.sv
package crc8lfr_pkg;

	localparam logic [7:0] CRC_POLY     = 8'h8C;
	localparam logic [7:0] ABORT_LENGTH = 8'h55;

	localparam logic [7:0] HEADER_RESET = 8'hAA;
	localparam logic [7:0] TAIL_RESET   = 8'hBB;
	localparam logic [5:0] MAXLEN_RESET = 6'd32;

	// configuration register indexes
	localparam logic [1:0] REG_HEADER = 2'd0;
	localparam logic [1:0] REG_TAIL   = 2'd1;
	localparam logic [1:0] REG_MAXLEN = 2'd2;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_ERROR   = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_BAD_LEN  = 2'd1,
		ERR_BAD_TAIL = 2'd2,
		ERR_BAD_CRC  = 2'd3
	} fault_code_t;

	typedef enum logic [2:0] {
		OUT_LEN_ERR  = 3'd0,
		OUT_TAIL_ERR = 3'd1,
		OUT_CRC_ERR  = 3'd2,
		OUT_EMPTY    = 3'd3,
		OUT_PAYLOAD  = 3'd4
	} out_sel_t;

	typedef struct packed {
		logic     len_load;
		logic     type_load;
		logic     pay_write;
		logic     crc_load;
		logic     rep_start;
		logic     rd_issue;
		logic     out_load;
		out_sel_t out_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_header;
		logic is_abort;
		logic over_limit;
		logic is_tail;
		logic crc_ok;
		logic len_zero;
		logic pay_last;
		logic rep_last;
		logic out_full;
	} dp_status_t;

	// reflected CRC-8, one byte
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[0])
				v = (v >> 1) ^ CRC_POLY;
			else
				v = v >> 1;
		end
		return v;
	endfunction

endpackage

FILE: hdl/crc8lfr_ctrl.sv
module crc8lfr_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  crc8lfr_pkg::dp_status_t status,
	output crc8lfr_pkg::ctrl_cmd_t  cmd
);
	import crc8lfr_pkg::*;

	typedef enum logic [7:0] {
		ST_WAIT    = 8'b0000_0001,
		ST_LEN     = 8'b0000_0010,
		ST_TYPE    = 8'b0000_0100,
		ST_PAYLOAD = 8'b0000_1000,
		ST_CRC     = 8'b0001_0000,
		ST_TAIL    = 8'b0010_0000,
		ST_READ    = 8'b0100_0000,
		ST_EMIT    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   resume_len_q, resume_len_d;
	logic   rx_phase;
	logic   take;
	state_t after_frame;

	assign rx_phase    = (state_q != ST_READ) && (state_q != ST_EMIT);
	assign in_ready    = rx_phase && !status.out_full;
	assign take        = in_valid && in_ready;
	assign after_frame = status.is_header ? ST_LEN : ST_WAIT;

	always_comb begin
		state_d      = state_q;
		resume_len_d = resume_len_q;
		cmd          = '0;
		cmd.out_sel  = OUT_PAYLOAD;
		unique case (state_q)
			ST_WAIT: begin
				if (take && status.is_header)
					state_d = ST_LEN;
			end
			ST_LEN: begin
				if (take) begin
					priority if (status.is_abort) begin
						state_d = ST_WAIT;
					end else if (status.over_limit) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = OUT_LEN_ERR;
						state_d      = after_frame;
					end else begin
						cmd.len_load = 1'b1;
						state_d      = ST_TYPE;
					end
				end
			end
			ST_TYPE: begin
				if (take) begin
					cmd.type_load = 1'b1;
					state_d       = status.len_zero ? ST_CRC : ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				if (take) begin
					cmd.pay_write = 1'b1;
					if (status.pay_last)
						state_d = ST_CRC;
				end
			end
			ST_CRC: begin
				if (take) begin
					cmd.crc_load = 1'b1;
					state_d      = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (take) begin
					priority if (!status.is_tail) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = OUT_TAIL_ERR;
						state_d      = after_frame;
					end else if (!status.crc_ok) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = OUT_CRC_ERR;
						state_d      = after_frame;
					end else if (status.len_zero) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = OUT_EMPTY;
						state_d      = after_frame;
					end else begin
						cmd.rep_start = 1'b1;
						resume_len_d  = status.is_header;
						state_d       = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.out_full) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_PAYLOAD;
					if (status.rep_last)
						state_d = resume_len_q ? ST_LEN : ST_WAIT;
					else
						state_d = ST_READ;
				end
			end
			default: state_d = ST_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_WAIT;
			resume_len_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			resume_len_q <= resume_len_d;
		end
	end

endmodule

FILE: hdl/crc8lfr_dp.sv
module crc8lfr_dp #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic [1:0]              cfg_index,
	input  logic [7:0]              cfg_data,
	input  logic [7:0]              rx_byte,
	input  crc8lfr_pkg::ctrl_cmd_t  cmd,
	output crc8lfr_pkg::dp_status_t status,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [1:0]              result_kind,
	output logic [1:0]              fault_code,
	output logic [7:0]              error_detail,
	output logic [7:0]              frame_type,
	output logic [5:0]              frame_length,
	output logic [4:0]              byte_position,
	output logic [7:0]              payload_value,
	output logic                    last_of_frame
);
	import crc8lfr_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [6:0] DEPTH7 = 7'(MAX_PAYLOAD);
	localparam logic [7:0] DEPTH8 = 8'(MAX_PAYLOAD);

	logic [7:0] header_q;
	logic [7:0] tail_q;
	logic [5:0] maxlen_q;

	logic [5:0] held_len_q;
	logic [7:0] held_type_q;
	logic [5:0] fill_q;
	logic [7:0] crc_q;
	logic [7:0] rx_crc_q;
	logic [5:0] rep_idx_q;
	logic [7:0] rd_data_q;

	logic [7:0] mem [MAX_PAYLOAD];

	logic [7:0] limit;
	logic [7:0] crc_next;
	logic [7:0] crc_base;
	logic       fill_in_range;

	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [1:0] code_q;
	logic [7:0] detail_q;
	logic [7:0] type_q;
	logic [5:0] len_q;
	logic [4:0] pos_q;
	logic [7:0] value_q;
	logic       last_q;

	// effective limit is the smaller of the register and the store depth
	assign limit = ({2'b00, maxlen_q} > DEPTH8) ? DEPTH8 : {2'b00, maxlen_q};

	assign crc_base      = cmd.len_load ? 8'h00 : crc_q;
	assign crc_next      = crc8_step(crc_base, rx_byte);
	assign fill_in_range = {1'b0, fill_q} < DEPTH7;

	assign status.is_header  = rx_byte == header_q;
	assign status.is_abort   = rx_byte == ABORT_LENGTH;
	assign status.over_limit = rx_byte > limit;
	assign status.is_tail    = rx_byte == tail_q;
	assign status.crc_ok     = rx_crc_q == crc_q;
	assign status.len_zero   = held_len_q == 6'd0;
	assign status.pay_last   = (fill_q + 6'd1) >= held_len_q;
	assign status.rep_last   = (rep_idx_q + 6'd1) == held_len_q;
	assign status.out_full   = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			tail_q   <= TAIL_RESET;
			maxlen_q <= MAXLEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER: header_q <= cfg_data;
				REG_TAIL:   tail_q   <= cfg_data;
				REG_MAXLEN: maxlen_q <= cfg_data[5:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_len_q  <= '0;
			held_type_q <= '0;
			fill_q      <= '0;
			crc_q       <= '0;
			rx_crc_q    <= '0;
			rep_idx_q   <= '0;
		end else begin
			if (cmd.len_load) begin
				held_len_q <= rx_byte[5:0];
				crc_q      <= crc_next;
			end
			if (cmd.type_load) begin
				held_type_q <= rx_byte;
				crc_q       <= crc_next;
				fill_q      <= '0;
			end
			if (cmd.pay_write) begin
				fill_q <= fill_q + 6'd1;
				crc_q  <= crc_next;
			end
			if (cmd.crc_load)
				rx_crc_q <= rx_byte;
			if (cmd.rep_start)
				rep_idx_q <= '0;
			else if (cmd.out_load && cmd.out_sel == OUT_PAYLOAD)
				rep_idx_q <= rep_idx_q + 6'd1;
		end
	end

	// payload store, registered read during replay
	always_ff @(posedge clk) begin
		if (cmd.pay_write && fill_in_range)
			mem[fill_q[AW-1:0]] <= rx_byte;
		if (cmd.rd_issue)
			rd_data_q <= mem[rep_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				OUT_LEN_ERR: begin
					kind_q   <= KIND_ERROR;
					code_q   <= ERR_BAD_LEN;
					detail_q <= rx_byte;
					type_q   <= 8'h00;
					len_q    <= 6'd0;
					pos_q    <= 5'd0;
					value_q  <= 8'h00;
					last_q   <= 1'b1;
				end
				OUT_TAIL_ERR: begin
					kind_q   <= KIND_ERROR;
					code_q   <= ERR_BAD_TAIL;
					detail_q <= rx_byte;
					type_q   <= held_type_q;
					len_q    <= held_len_q;
					pos_q    <= 5'd0;
					value_q  <= 8'h00;
					last_q   <= 1'b1;
				end
				OUT_CRC_ERR: begin
					kind_q   <= KIND_ERROR;
					code_q   <= ERR_BAD_CRC;
					detail_q <= held_type_q;
					type_q   <= held_type_q;
					len_q    <= held_len_q;
					pos_q    <= 5'd0;
					value_q  <= 8'h00;
					last_q   <= 1'b1;
				end
				OUT_EMPTY: begin
					kind_q   <= KIND_EMPTY;
					code_q   <= ERR_NONE;
					detail_q <= 8'h00;
					type_q   <= held_type_q;
					len_q    <= 6'd0;
					pos_q    <= 5'd0;
					value_q  <= 8'h00;
					last_q   <= 1'b1;
				end
				default: begin
					kind_q   <= KIND_PAYLOAD;
					code_q   <= ERR_NONE;
					detail_q <= 8'h00;
					type_q   <= held_type_q;
					len_q    <= held_len_q;
					pos_q    <= rep_idx_q[4:0];
					value_q  <= rd_data_q;
					last_q   <= status.rep_last;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign fault_code    = code_q;
	assign error_detail  = detail_q;
	assign frame_type    = type_q;
	assign frame_length  = len_q;
	assign byte_position = pos_q;
	assign payload_value = value_q;
	assign last_of_frame = last_q;

endmodule

FILE: hdl/crc8_length_frame_receiver.sv
// Deframes header, length, type, payload, crc, tail from a byte stream with a reflected
// CRC-8 (poly 0x8C, init 0) over length, type and payload. Frame bytes are taken one per
// cycle whenever the output register is free. A good frame is then replayed from the
// single-port payload store, one registered read and one output load per byte, and no
// input request is taken meanwhile. A bad length gives one result off the length byte;
// other errors and empty frames give one off the tail. The store needs no clearing after
// reset. Configuration writes are always accepted (cfg_ready is tied high).
module crc8_length_frame_receiver #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] result_kind,
	output logic [1:0] fault_code,
	output logic [7:0] error_detail,
	output logic [7:0] frame_type,
	output logic [5:0] frame_length,
	output logic [4:0] byte_position,
	output logic [7:0] payload_value,
	output logic       last_of_frame,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import crc8lfr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	crc8lfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	crc8lfr_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.result_kind   (result_kind),
		.fault_code    (fault_code),
		.error_detail  (error_detail),
		.frame_type    (frame_type),
		.frame_length  (frame_length),
		.byte_position (byte_position),
		.payload_value (payload_value),
		.last_of_frame (last_of_frame)
	);

endmodule

FILE: test/tb_crc8_length_frame_receiver.sv
`timescale 1ns / 100ps

module tb_crc8_length_frame_receiver;
	import crc8lfr_pkg::*;

	localparam int         PAYLOAD_SLOTS    = 32;
	localparam logic [7:0] CRC8_REFL_POLY   = 8'h8C;
	localparam logic [7:0] ABORT_LEN        = 8'h55;
	localparam int         SETTLE_CYCLES    = 16;
	localparam int         REPLAY_CYCLES    = 2 * PAYLOAD_SLOTS + 8;
	localparam int         LONG_HOLD_CYCLES = 400;
	localparam int         WATCHDOG_LIMIT   = 3000;
	localparam int         PHASE_BYTES      = 64;

	typedef enum logic [2:0] {
		RX_HUNT, RX_LENGTH, RX_TYPE, RX_PAYLOAD, RX_CRC, RX_TAIL
	} rx_phase_t;

	typedef enum logic [1:0] {CRC_AS_IS, CRC_GOOD, CRC_BAD} crc_fill_t;

	typedef struct {
		result_kind_t kind;
		fault_code_t  code;
		logic [7:0]   detail;
		logic [7:0]   ftype;
		logic [5:0]   flen;
		logic [4:0]   pos;
		logic [7:0]   value;
		logic         last;
	} frame_result_t;

	typedef struct {
		logic [7:0]    value;
		crc_fill_t     fill;
		bit            typed;
		frame_result_t want;
	} link_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] result_kind;
	logic [1:0] fault_code;
	logic [7:0] error_detail;
	logic [7:0] frame_type;
	logic [5:0] frame_length;
	logic [4:0] byte_position;
	logic [7:0] payload_value;
	logic       last_of_frame;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = REG_HEADER;
	logic [7:0] cfg_data = 8'h00;

	// predictor state and its copy of the registers
	rx_phase_t  p_phase = RX_HUNT;
	logic [7:0] p_header = 8'hAA;
	logic [7:0] p_tail = 8'hBB;
	logic [5:0] p_maxlen = 6'd32;
	logic [5:0] p_len = '0;
	logic [7:0] p_type = '0;
	int         p_fill = 0;
	logic [7:0] p_crc = '0;
	logic [7:0] p_rx_crc = '0;
	logic [7:0] p_store [PAYLOAD_SLOTS];

	frame_result_t pending_results[$];
	bit            typed_armed = 1'b0;
	frame_result_t typed_want;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	bit long_hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	int link_bytes = 0;
	int frames_sent = 0;
	int flawed_frames = 0;
	int results_checked = 0;
	int mismatches = 0;

	crc8_length_frame_receiver #(.MAX_PAYLOAD(PAYLOAD_SLOTS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .fault_code(fault_code), .error_detail(error_detail),
		.frame_type(frame_type), .frame_length(frame_length),
		.byte_position(byte_position), .payload_value(payload_value),
		.last_of_frame(last_of_frame),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++)
			v = v[0] ? ((v >> 1) ^ CRC8_REFL_POLY) : (v >> 1);
		return v;
	endfunction

	function automatic frame_result_t mk_result(input result_kind_t kind, input fault_code_t code,
			input logic [7:0] detail, input logic [7:0] ftype, input logic [5:0] flen,
			input logic [4:0] pos, input logic [7:0] value, input logic last);
		frame_result_t r;
		r.kind = kind;
		r.code = code;
		r.detail = detail;
		r.ftype = ftype;
		r.flen = flen;
		r.pos = pos;
		r.value = value;
		r.last = last;
		return r;
	endfunction

	function automatic link_row_t link_row(input logic [7:0] value, input crc_fill_t fill);
		link_row_t r;
		r.value = value;
		r.fill = fill;
		r.typed = 1'b0;
		r.want = mk_result(KIND_PAYLOAD, ERR_NONE, 8'h00, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0);
		return r;
	endfunction

	function automatic link_row_t typed_row(input logic [7:0] value, input frame_result_t want);
		link_row_t r;
		r = link_row(value, CRC_AS_IS);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	// one accepted link byte through the deframer
	task automatic predict_link_byte(input logic [7:0] b);
		int lim;
		int i;
		lim = (p_maxlen > PAYLOAD_SLOTS) ? PAYLOAD_SLOTS : p_maxlen;
		case (p_phase)
			RX_HUNT: begin
				if (b == p_header)
					p_phase = RX_LENGTH;
			end
			RX_LENGTH: begin
				// abort test comes before the limit test
				if (b == ABORT_LEN) begin
					p_phase = RX_HUNT;
				end else if (b > lim) begin
					pending_results.push_back(mk_result(KIND_ERROR, ERR_BAD_LEN, b, 8'h00,
						6'd0, 5'd0, 8'h00, 1'b1));
					p_phase = (b == p_header) ? RX_LENGTH : RX_HUNT;
				end else begin
					p_len = b[5:0];
					p_crc = crc8_next(8'h00, b);
					p_phase = RX_TYPE;
				end
			end
			RX_TYPE: begin
				p_type = b;
				p_crc = crc8_next(p_crc, b);
				p_fill = 0;
				p_phase = (p_len == 0) ? RX_CRC : RX_PAYLOAD;
			end
			RX_PAYLOAD: begin
				if (p_fill < PAYLOAD_SLOTS)
					p_store[p_fill] = b;
				p_fill++;
				p_crc = crc8_next(p_crc, b);
				if (p_fill >= p_len)
					p_phase = RX_CRC;
			end
			RX_CRC: begin
				p_rx_crc = b;
				p_phase = RX_TAIL;
			end
			RX_TAIL: begin
				// wrong tail wins over a crc mismatch
				if (b != p_tail) begin
					pending_results.push_back(mk_result(KIND_ERROR, ERR_BAD_TAIL, b, p_type,
						p_len, 5'd0, 8'h00, 1'b1));
				end else if (p_rx_crc != p_crc) begin
					pending_results.push_back(mk_result(KIND_ERROR, ERR_BAD_CRC, p_type, p_type,
						p_len, 5'd0, 8'h00, 1'b1));
				end else if (p_len == 0) begin
					pending_results.push_back(mk_result(KIND_EMPTY, ERR_NONE, 8'h00, p_type,
						6'd0, 5'd0, 8'h00, 1'b1));
				end else begin
					for (i = 0; i < p_len; i++)
						pending_results.push_back(mk_result(KIND_PAYLOAD, ERR_NONE, 8'h00,
							p_type, p_len, i[4:0], p_store[i], (i + 1 == p_len)));
				end
				p_phase = (b == p_header) ? RX_LENGTH : RX_HUNT;
			end
			default: p_phase = RX_HUNT;
		endcase
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			note_mismatch($sformatf("result %0d %s is %0h, expected %0h",
				results_checked, name, got, want));
	endtask

	task automatic check_result();
		frame_result_t want;
		if (pending_results.size() == 0) begin
			note_mismatch($sformatf("unexpected result, kind %0d detail %0h",
				result_kind, error_detail));
		end else begin
			want = pending_results.pop_front();
			results_checked++;
			check_field("result_kind", 8'(result_kind), 8'(want.kind));
			check_field("fault_code", 8'(fault_code), 8'(want.code));
			check_field("error_detail", error_detail, want.detail);
			check_field("frame_type", frame_type, want.ftype);
			check_field("frame_length", 8'(frame_length), 8'(want.flen));
			check_field("byte_position", 8'(byte_position), 8'(want.pos));
			check_field("payload_value", payload_value, want.value);
			check_field("last_of_frame", 8'(last_of_frame), 8'(want.last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready) begin
				int queued;
				queued = pending_results.size();
				link_bytes++;
				predict_link_byte(rx_byte);
				// directed rows with a hand-written result replace the prediction
				if (typed_armed) begin
					repeat (pending_results.size() - queued)
						void'(pending_results.pop_back());
					pending_results.push_back(typed_want);
					typed_armed = 1'b0;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HEADER: p_header = cfg_data;
					REG_TAIL:   p_tail = cfg_data;
					REG_MAXLEN: p_maxlen = cfg_data[5:0];
					default: ;
				endcase
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_link_byte(input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_settings(input logic [7:0] hdr, input logic [7:0] tl,
			input logic [5:0] maxlen);
		logic [1:0] idx [3];
		logic [7:0] val [3];
		idx[0] = REG_HEADER;
		idx[1] = REG_TAIL;
		idx[2] = REG_MAXLEN;
		val[0] = hdr;
		val[1] = tl;
		val[2] = {2'b00, maxlen};
		for (int r = 0; r < 3; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[r];
			cfg_data <= val[r];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed frames with random content; n counts frame bytes, not noise
	task automatic send_random_frame(output int n);
		int roll;
		int lim;
		int len;
		int i;
		logic [7:0] crc;
		logic [7:0] ftype;
		logic [7:0] v;
		n = 0;
		roll = $urandom_range(99);
		lim = (p_maxlen > PAYLOAD_SLOTS) ? PAYLOAD_SLOTS : p_maxlen;
		if (roll >= 93) begin
			repeat ($urandom_range(4, 1)) send_link_byte(8'($urandom_range(255)));
			return;
		end
		frames_sent++;
		if (roll >= 70)
			flawed_frames++;
		send_link_byte(p_header);
		if (roll >= 70 && roll < 80) begin
			if (roll < 75) begin
				v = ABORT_LEN;
			end else begin
				do v = 8'($urandom_range(255, lim + 1)); while (v == ABORT_LEN);
			end
			send_link_byte(v);
			n = 2;
			return;
		end
		len = ($urandom_range(9) == 0) ? lim : $urandom_range((lim < 8) ? lim : 8, 0);
		ftype = 8'($urandom_range(255));
		crc = crc8_next(crc8_next(8'h00, len[7:0]), ftype);
		send_link_byte(len[7:0]);
		send_link_byte(ftype);
		for (i = 0; i < len; i++) begin
			v = 8'($urandom_range(255));
			crc = crc8_next(crc, v);
			send_link_byte(v);
		end
		if (roll >= 80 && roll < 87)
			crc = crc ^ 8'($urandom_range(255, 1));
		send_link_byte(crc);
		if (roll >= 87) begin
			do v = 8'($urandom_range(255)); while (v == p_tail);
		end else begin
			v = p_tail;
		end
		send_link_byte(v);
		n = len + 5;
	endtask

	initial begin
		link_row_t directed[$];
		logic [7:0] v;
		int budget;
		int n;
		int p;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: header AA, tail BB, limit 32
		directed.push_back(link_row(8'hAA, CRC_AS_IS));
		directed.push_back(link_row(ABORT_LEN, CRC_AS_IS));
		directed.push_back(link_row(8'hAA, CRC_AS_IS));
		directed.push_back(typed_row(8'h21, mk_result(KIND_ERROR, ERR_BAD_LEN, 8'h21, 8'h00,
			6'd0, 5'd0, 8'h00, 1'b1)));
		// empty frame
		directed.push_back(link_row(8'hAA, CRC_AS_IS));
		directed.push_back(link_row(8'h00, CRC_AS_IS));
		directed.push_back(link_row(8'hFF, CRC_AS_IS));
		directed.push_back(link_row(8'h00, CRC_GOOD));
		directed.push_back(typed_row(8'hBB, mk_result(KIND_EMPTY, ERR_NONE, 8'h00, 8'hFF,
			6'd0, 5'd0, 8'h00, 1'b1)));
		// bad crc and bad tail together: tail reported, and the tail is a header
		directed.push_back(link_row(8'hAA, CRC_AS_IS));
		directed.push_back(link_row(8'h01, CRC_AS_IS));
		directed.push_back(link_row(8'h12, CRC_AS_IS));
		directed.push_back(link_row(8'h00, CRC_AS_IS));
		directed.push_back(link_row(8'h00, CRC_BAD));
		directed.push_back(typed_row(8'hAA, mk_result(KIND_ERROR, ERR_BAD_TAIL, 8'hAA, 8'h12,
			6'd1, 5'd0, 8'h00, 1'b1)));
		// straight into the length, no header in between
		directed.push_back(link_row(8'h02, CRC_AS_IS));
		directed.push_back(link_row(8'h5A, CRC_AS_IS));
		directed.push_back(link_row(8'hFF, CRC_AS_IS));
		directed.push_back(link_row(8'h80, CRC_AS_IS));
		directed.push_back(link_row(8'h00, CRC_BAD));
		directed.push_back(typed_row(8'hBB, mk_result(KIND_ERROR, ERR_BAD_CRC, 8'h5A, 8'h5A,
			6'd2, 5'd0, 8'h00, 1'b1)));
		// small good frame
		directed.push_back(link_row(8'hAA, CRC_AS_IS));
		directed.push_back(link_row(8'h01, CRC_AS_IS));
		directed.push_back(link_row(8'h3C, CRC_AS_IS));
		directed.push_back(link_row(8'h7F, CRC_AS_IS));
		directed.push_back(link_row(8'h00, CRC_GOOD));
		directed.push_back(link_row(8'hBB, CRC_AS_IS));

		foreach (directed[k]) begin
			v = directed[k].value;
			if (directed[k].fill == CRC_GOOD)
				v = p_crc;
			else if (directed[k].fill == CRC_BAD)
				v = p_crc ^ 8'h01;
			typed_armed = directed[k].typed;
			typed_want = directed[k].want;
			send_link_byte(v);
		end
		wait_drained();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: write_settings(8'hAA, 8'hBB, 6'd32);
				1: write_settings(8'h00, 8'hFF, 6'd0);
				2: write_settings(8'hFF, 8'h00, 6'd32);
				3: write_settings(8'h05, 8'h55, 6'd8);   // header fits as a length
				4: write_settings(8'h7E, 8'h7E, 6'd20);  // tail doubles as header
				default: write_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					6'($urandom_range(32, 0)));
			endcase
			sender_idle_pct = (p % 4 == 1) ? 53 : (p % 4 == 3) ? 36 : 0;
			receiver_stall_pct = (p % 4 == 2) ? 53 : (p % 4 == 3) ? 36 : 0;
			if (p == 2)
				long_hold_req = 1'b1;
			budget = 0;
			while (budget < PHASE_BYTES) begin
				send_random_frame(n);
				budget += n;
				// in phase 0 the sender waits mid-phase for every result
				if (p == 0 && budget >= PHASE_BYTES / 2 && budget - n < PHASE_BYTES / 2)
					wait_drained();
			end
			wait_drained();
		end

		repeat (REPLAY_CYCLES) @(negedge clk);
		if (pending_results.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		$display("run: %0d link bytes, %0d random frames (%0d flawed), six register settings",
			link_bytes, frames_sent, flawed_frames);
		$display("run: %0d results compared, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
hdl/crc8lfr_pkg.sv
hdl/crc8lfr_ctrl.sv
hdl/crc8lfr_dp.sv
hdl/crc8_length_frame_receiver.sv
test/tb_crc8_length_frame_receiver.sv
